@@ rtl/edc_pkg.sv @@
// edc_pkg: shared types and constants of the edit distance engine
// command codes, wavefront operation codes and the per-stage control struct
// no dependencies
package edc_pkg;

    // host command codes
    localparam logic [1:0] CMD_APPEND  = 2'd0;
    localparam logic [1:0] CMD_COMPARE = 2'd1;
    localparam logic [1:0] CMD_END     = 2'd2;

    // result field width and saturation value
    localparam int         DIST_W   = 12;
    localparam logic [DIST_W-1:0] DIST_MAX = 12'hFFF;

    // operation carried by a wavefront token
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_CMP   = 2'd1,
        OP_READ  = 2'd2
    } edc_op_t;

    // control group handed from cell to cell
    typedef struct packed {
        logic       vld;
        edc_op_t    op;
        logic       fin;
        logic       wen;
        logic       ovf;
        logic [7:0] ch;
    } edc_ctl_t;

endpackage

@@ rtl/edit_distance_engine.sv @@
// edit_distance_engine: Levenshtein distance of a streamed string against a
// stored pattern, one transaction per clock; each transaction's token passes
// the issue register, then walks the cell row one cell per cycle to the result.
// Throughput is one transaction per cycle; busy stays low and the receiver
// cannot stall. Reset clears pattern length, string count, overflow flag and
// sets row entry i to i plus one in every cell at once.
// depends on edc_pkg and edc_cell
module edit_distance_engine #(
    parameter int MAX_PATTERN_LEN = 64,
    parameter int MAX_STRING_LEN  = 4095
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                cmd,
    input  logic [7:0]                ch,
    input  logic                      first,
    input  logic                      last,
    output logic                      done,
    output logic [edc_pkg::DIST_W-1:0] distance,
    output logic                      overflow
);
    import edc_pkg::*;

    localparam int LW = $clog2(MAX_PATTERN_LEN + 1);
    localparam int CW = $clog2(MAX_STRING_LEN + 1);
    localparam int RW = $clog2(MAX_PATTERN_LEN + MAX_STRING_LEN + 1);
    localparam int XW = (RW > DIST_W) ? RW : DIST_W;

    logic          accept;
    logic [LW-1:0] len_reg;
    logic [LW-1:0] len_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          ovf_reg;
    logic          ovf_next;

    edc_ctl_t      inj_ctl_reg;
    edc_ctl_t      inj_ctl_next;
    logic [LW-1:0] inj_pos_reg;
    logic [LW-1:0] inj_pos_next;
    logic [LW-1:0] inj_len_reg;
    logic [LW-1:0] inj_len_next;
    logic [RW-1:0] inj_diag_reg;
    logic [RW-1:0] inj_diag_next;
    logic [RW-1:0] inj_left_reg;
    logic [RW-1:0] inj_left_next;

    edc_ctl_t      ctl_link  [0:MAX_PATTERN_LEN];
    logic [LW-1:0] pos_link  [0:MAX_PATTERN_LEN];
    logic [LW-1:0] len_link  [0:MAX_PATTERN_LEN];
    logic [RW-1:0] diag_link [0:MAX_PATTERN_LEN];
    logic [RW-1:0] left_link [0:MAX_PATTERN_LEN];

    logic [XW-1:0] dist_ext;
    logic          dist_sat;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // command decode and token build
    always_comb
    begin
        logic [LW-1:0] base_len;
        logic          base_ovf;
        logic          cnt_sat;
        logic [CW-1:0] cnt_inc;

        cnt_sat  = count_reg >= CW'(MAX_STRING_LEN);
        cnt_inc  = cnt_sat ? count_reg : count_reg + 1'b1;
        base_len = first ? '0 : len_reg;
        base_ovf = first ? 1'b0 : ovf_reg;

        len_next      = len_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        inj_ctl_next  = '{vld: 1'b0, op: OP_WRITE, fin: 1'b0, wen: 1'b0,
                          ovf: 1'b0, ch: ch};
        inj_pos_next  = '0;
        inj_len_next  = len_reg;
        inj_diag_next = RW'(count_reg);
        inj_left_next = RW'(count_reg);

        if (accept)
        begin
            unique case (cmd)
                CMD_APPEND:
                begin
                    inj_ctl_next.vld = 1'b1;
                    inj_ctl_next.op  = OP_WRITE;
                    count_next       = '0;
                    if (base_len < LW'(MAX_PATTERN_LEN))
                    begin
                        inj_ctl_next.wen = 1'b1;
                        inj_pos_next     = base_len;
                        len_next         = base_len + 1'b1;
                        ovf_next         = base_ovf;
                    end
                    else
                    begin
                        len_next = base_len;
                        ovf_next = 1'b1;
                    end
                    inj_len_next = len_next;
                end
                CMD_COMPARE:
                begin
                    ovf_next         = ovf_reg | cnt_sat;
                    count_next       = last ? '0 : cnt_inc;
                    inj_ctl_next.vld = 1'b1;
                    inj_ctl_next.op  = OP_CMP;
                    inj_ctl_next.fin = last;
                    inj_ctl_next.ovf = ovf_reg | cnt_sat;
                    // empty pattern: the distance is the updated count
                    if (len_reg == '0)
                    begin
                        inj_left_next = RW'(cnt_inc);
                    end
                end
                CMD_END:
                begin
                    count_next       = '0;
                    inj_ctl_next.vld = 1'b1;
                    inj_ctl_next.op  = OP_READ;
                    inj_ctl_next.fin = 1'b1;
                    inj_ctl_next.ovf = ovf_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    // control state and token issue register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= '0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            inj_ctl_reg <= '0;
        end
        else
        begin
            len_reg     <= len_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            inj_ctl_reg <= inj_ctl_next;
        end
    end

    // token payload
    always_ff @(posedge clk)
    begin
        inj_pos_reg  <= inj_pos_next;
        inj_len_reg  <= inj_len_next;
        inj_diag_reg <= inj_diag_next;
        inj_left_reg <= inj_left_next;
    end

    assign ctl_link[0]  = inj_ctl_reg;
    assign pos_link[0]  = inj_pos_reg;
    assign len_link[0]  = inj_len_reg;
    assign diag_link[0] = inj_diag_reg;
    assign left_link[0] = inj_left_reg;

    // row of cells, one per pattern position
    for (genvar i = 0; i < MAX_PATTERN_LEN; i++)
    begin : g_cell
        edc_cell #(
            .IDX (i),
            .LW  (LW),
            .RW  (RW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl_in   (ctl_link[i]),
            .pos_in   (pos_link[i]),
            .len_in   (len_link[i]),
            .diag_in  (diag_link[i]),
            .left_in  (left_link[i]),
            .ctl_out  (ctl_link[i+1]),
            .pos_out  (pos_link[i+1]),
            .len_out  (len_link[i+1]),
            .diag_out (diag_link[i+1]),
            .left_out (left_link[i+1])
        );
    end

    // result at the end of the row, saturated to the field width
    assign dist_ext = XW'(left_link[MAX_PATTERN_LEN]);
    assign dist_sat = dist_ext > XW'(DIST_MAX);
    assign done     = ctl_link[MAX_PATTERN_LEN].vld && ctl_link[MAX_PATTERN_LEN].fin;
    assign distance = dist_sat ? DIST_MAX : dist_ext[DIST_W-1:0];
    assign overflow = ctl_link[MAX_PATTERN_LEN].ovf || dist_sat;

    // a token is only issued for an accepted transaction
    a_issue_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        inj_ctl_reg.vld |-> $past(accept))
        else $error("token issued without an accepted transaction");

    // pattern length never passes capacity
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LW'(MAX_PATTERN_LEN))
        else $error("pattern length beyond capacity");

    // string count saturates at its limit
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_STRING_LEN))
        else $error("string count beyond limit");

    // a new pattern restarts length and clears the overflow flag
    a_new_pattern: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd == CMD_APPEND) && first) |=> (len_reg == LW'(1)) && !ovf_reg)
        else $error("new pattern did not restart state");

endmodule

@@ rtl/edc_cell.sv @@
// edc_cell: one cell of the systolic row, holding one pattern byte and one
// row entry; updates its entry as the wavefront token passes
// depends on edc_pkg
module edc_cell #(
    parameter int IDX = 0,
    parameter int LW  = 7,
    parameter int RW  = 13
) (
    input  logic              clk,
    input  logic              rst_n,
    input  edc_pkg::edc_ctl_t ctl_in,
    input  logic [LW-1:0]     pos_in,
    input  logic [LW-1:0]     len_in,
    input  logic [RW-1:0]     diag_in,
    input  logic [RW-1:0]     left_in,
    output edc_pkg::edc_ctl_t ctl_out,
    output logic [LW-1:0]     pos_out,
    output logic [LW-1:0]     len_out,
    output logic [RW-1:0]     diag_out,
    output logic [RW-1:0]     left_out
);
    import edc_pkg::*;

    localparam logic [RW-1:0] ROW_INIT = RW'(IDX + 1);

    logic [7:0]    pat_reg;
    logic [7:0]    pat_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    edc_ctl_t      ctl_reg;
    logic [LW-1:0] pos_reg;
    logic [LW-1:0] len_reg;
    logic [RW-1:0] diag_reg;
    logic [RW-1:0] diag_next;
    logic [RW-1:0] left_reg;
    logic [RW-1:0] left_next;

    logic          active;
    logic [RW-1:0] sub;
    logic [RW-1:0] cell_val;

    // one step of the single-row recurrence
    always_comb
    begin
        active = LW'(IDX) < len_in;
        sub    = (ctl_in.ch == pat_reg) ? diag_in : diag_in + 1'b1;
        if (row_reg > left_in)
        begin
            cell_val = (sub > left_in) ? left_in + 1'b1 : sub;
        end
        else
        begin
            cell_val = (sub > row_reg) ? row_reg + 1'b1 : sub;
        end
    end

    // token handling per operation
    always_comb
    begin
        pat_next  = pat_reg;
        row_next  = row_reg;
        diag_next = diag_in;
        left_next = left_in;
        if (ctl_in.vld)
        begin
            case (ctl_in.op)
                OP_WRITE:
                begin
                    if (ctl_in.wen && (pos_in == LW'(IDX)))
                    begin
                        pat_next = ctl_in.ch;
                    end
                    row_next = ROW_INIT;
                end
                OP_CMP:
                begin
                    if (active)
                    begin
                        diag_next = row_reg;
                        left_next = cell_val;
                        row_next  = ctl_in.fin ? ROW_INIT : cell_val;
                    end
                    else if (ctl_in.fin)
                    begin
                        row_next = ROW_INIT;
                    end
                end
                OP_READ:
                begin
                    if (active)
                    begin
                        left_next = row_reg;
                    end
                    row_next = ROW_INIT;
                end
                default:
                begin
                end
            endcase
        end
    end

    // control state and row entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
            row_reg <= ROW_INIT;
        end
        else
        begin
            ctl_reg <= ctl_in;
            row_reg <= row_next;
        end
    end

    // payload carried to the next cell
    always_ff @(posedge clk)
    begin
        pat_reg  <= pat_next;
        pos_reg  <= pos_in;
        len_reg  <= len_in;
        diag_reg <= diag_next;
        left_reg <= left_next;
    end

    assign ctl_out  = ctl_reg;
    assign pos_out  = pos_reg;
    assign len_out  = len_reg;
    assign diag_out = diag_reg;
    assign left_out = left_reg;

endmodule

@@ dv/tb_top.sv @@
// tb_top: self-checking testbench for edit_distance_engine
// predicts each distance from its own copy of the pattern and row state
// depends on edc_pkg and the edit_distance_engine rtl
module tb_top;

    import edc_pkg::*;

    localparam int PAT_CAP      = 64;
    localparam int STR_CAP      = 4095;
    localparam int PIPE_LAT     = PAT_CAP + 1;
    localparam int RANDOM_ITEMS = 950;
    localparam int CYCLE_LIMIT  = 300000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [DIST_W-1:0] dist_val;
        logic              ovf;
    } edit_result_t;

    typedef logic [7:0] byte_seq_t [$];

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        cmd;
    logic [7:0]        ch;
    logic              first;
    logic              last;
    logic              done;
    logic [DIST_W-1:0] distance;
    logic              overflow;

    // predictor state
    logic [7:0]   pat_bytes [PAT_CAP];
    int unsigned  dp_row [PAT_CAP];
    int unsigned  pat_len;
    int unsigned  str_len;
    bit           ovf_sticky;
    edit_result_t expected_results [$];
    edit_result_t oldest_result;

    int mismatch_cnt = 0;
    int cycle_cnt    = 0;
    int items_sent   = 0;
    int burst_left   = 0;

    edit_distance_engine #(
        .MAX_PATTERN_LEN (PAT_CAP),
        .MAX_STRING_LEN  (STR_CAP)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .ch       (ch),
        .first    (first),
        .last     (last),
        .done     (done),
        .distance (distance),
        .overflow (overflow)
    );

    // clock
    always #5 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("ERROR: timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, expected_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR: %s", msg);
        mismatch_cnt++;
    endtask

    // row re-initialisation, also clears the string length
    function automatic void clear_row();
        for (int i = 0; i < PAT_CAP; i++)
            dp_row[i] = i + 1;
        str_len = 0;
    endfunction

    // end of string: distance read from the row, saturated to the field
    function automatic void close_string();
        int unsigned  d;
        edit_result_t r;
        d = (pat_len == 0) ? str_len : dp_row[pat_len - 1];
        r.ovf = ovf_sticky;
        if (d > DIST_MAX)
        begin
            d = DIST_MAX;
            r.ovf = 1'b1;
        end
        r.dist_val = d[DIST_W-1:0];
        expected_results.push_back(r);
        clear_row();
    endfunction

    // single-row dynamic programming update for one string byte
    function automatic void advance_row(input logic [7:0] c);
        int unsigned diag;
        int unsigned left;
        int unsigned up;
        int unsigned sub;
        int unsigned v;
        diag = str_len;
        left = str_len;
        for (int i = 0; i < pat_len; i++)
        begin
            sub = (c == pat_bytes[i]) ? diag : diag + 1;
            up  = dp_row[i];
            if (up > left)
                v = (sub > left) ? left + 1 : sub;
            else
                v = (sub > up) ? up + 1 : sub;
            diag      = up;
            dp_row[i] = v;
            left      = v;
        end
        if (str_len < STR_CAP)
            str_len++;
        else
            ovf_sticky = 1'b1;
    endfunction

    function automatic void predict_edit_step(input logic [1:0] c_cmd, input logic [7:0] c_ch,
                                              input logic c_first, input logic c_last);
        case (c_cmd)
            CMD_APPEND:
            begin
                if (c_first)
                begin
                    pat_len    = 0;
                    ovf_sticky = 1'b0;
                end
                if (pat_len < PAT_CAP)
                begin
                    pat_bytes[pat_len] = c_ch;
                    pat_len++;
                end
                else
                    ovf_sticky = 1'b1;
                clear_row();
            end
            CMD_COMPARE:
            begin
                advance_row(c_ch);
                if (c_last)
                    close_string();
            end
            CMD_END:
                close_string();
            default:
                ;
        endcase
    endfunction

    // result checker, sampled away from the driving edge
    always @(negedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected result distance=%0d overflow=%0b",
                                          distance, overflow));
            else
            begin
                oldest_result = expected_results.pop_front();
                if (distance !== oldest_result.dist_val)
                    report_mismatch($sformatf("distance %0d, expected %0d",
                                              distance, oldest_result.dist_val));
                if (overflow !== oldest_result.ovf)
                    report_mismatch($sformatf("overflow %0b, expected %0b",
                                              overflow, oldest_result.ovf));
            end
        end
    end

    // one transaction; entered and left at a rising edge, then bursts and gaps
    task automatic send_item(input logic [1:0] c_cmd, input logic [7:0] c_ch,
                             input logic c_first, input logic c_last);
        int gap;
        start <= 1'b1;
        cmd   <= c_cmd;
        ch    <= c_ch;
        first <= c_first;
        last  <= c_last;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        predict_edit_step(c_cmd, c_ch, c_first, c_last);
        if (c_cmd != CMD_UNUSED)
            items_sent++;
        @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // sender holds off until every outstanding result is back
    task automatic drain_results();
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic byte_seq_t text_bytes(input string s);
        byte_seq_t seq;
        for (int i = 0; i < s.len(); i++)
            seq.push_back(s[i]);
        return seq;
    endfunction

    // narrow alphabet gives frequent matches
    function automatic byte_seq_t random_bytes(input int len, input bit narrow);
        byte_seq_t seq;
        for (int i = 0; i < len; i++)
            seq.push_back(narrow ? 8'h61 + 8'($urandom_range(0, 3)) : 8'($urandom));
        return seq;
    endfunction

    task automatic load_pattern(input byte_seq_t pat);
        for (int i = 0; i < pat.size(); i++)
            send_item(CMD_APPEND, pat[i], i == 0, 1'($urandom));
    endtask

    // string ends on a marked byte, or by the end command when empty or asked
    task automatic stream_string(input byte_seq_t s, input bit end_by_cmd);
        for (int i = 0; i < s.size(); i++)
            send_item(CMD_COMPARE, s[i], 1'($urandom), (i == s.size() - 1) && !end_by_cmd);
        if (s.size() == 0 || end_by_cmd)
            send_item(CMD_END, 8'($urandom), 1'($urandom), 1'($urandom));
    endtask

    // empty pattern straight after reset
    task automatic test_empty_pattern();
        stream_string(text_bytes(""), 1'b1);
        stream_string(text_bytes("abc"), 1'b0);
        stream_string(text_bytes("ab"), 1'b1);
    endtask

    // byte extremes and an empty third string
    task automatic test_byte_extremes();
        load_pattern('{8'h00, 8'hFF});
        stream_string('{8'hFF, 8'h00}, 1'b0);
        stream_string('{8'h00, 8'hFF}, 1'b1);
        stream_string(text_bytes(""), 1'b1);
    endtask

    // classic pair, abandoned string, unused command, ignored flags
    task automatic test_abandon_and_ignore();
        load_pattern(text_bytes("kitten"));
        stream_string(text_bytes("sitting"), 1'b0);
        send_item(CMD_COMPARE, "x", 1'b1, 1'b0);
        send_item(CMD_UNUSED, 8'hA5, 1'b1, 1'b1);
        send_item(CMD_COMPARE, "y", 1'b0, 1'b0);
        send_item(CMD_APPEND, "s", 1'b0, 1'b1);
        stream_string(text_bytes("kitten"), 1'b0);
    endtask

    // pattern beyond capacity, sticky overflow, cleared by a new pattern
    task automatic test_pattern_full();
        load_pattern(random_bytes(PAT_CAP + 2, 1'b1));
        stream_string(random_bytes(5, 1'b1), 1'b0);
        stream_string(random_bytes(3, 1'b1), 1'b1);
        load_pattern(text_bytes("ab"));
        stream_string(text_bytes("ab"), 1'b0);
    endtask

    // string count saturation, then distance saturation
    task automatic test_long_string();
        byte_seq_t long_seq;
        repeat (STR_CAP + 2) long_seq.push_back(8'h62);
        load_pattern(text_bytes("a"));
        stream_string(long_seq, 1'b0);
        stream_string(text_bytes("a"), 1'b0);
    endtask

    // mostly well-formed pattern and string sequences, some noise
    task automatic test_random_traffic();
        int base;
        int roll;
        int plen;
        int slen;
        int nstr;
        bit narrow;
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
            begin
                narrow = ($urandom_range(0, 4) != 0);
                if ($urandom_range(0, 3) != 0)
                begin
                    roll = $urandom_range(0, 19);
                    if (roll == 0)
                        plen = $urandom_range(PAT_CAP + 1, PAT_CAP + 6);
                    else if (roll < 3)
                        plen = $urandom_range(11, PAT_CAP);
                    else
                        plen = $urandom_range(1, 10);
                    load_pattern(random_bytes(plen, narrow));
                end
                nstr = $urandom_range(1, 4);
                for (int k = 0; k < nstr; k++)
                begin
                    slen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 70)
                                                       : $urandom_range(0, 12);
                    stream_string(random_bytes(slen, narrow), $urandom_range(0, 3) == 0);
                end
            end
            else if (roll < 95)
            begin
                repeat ($urandom_range(1, 8))
                    send_item(2'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
            end
            else
                drain_results();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd   = CMD_APPEND;
        ch    = 8'h00;
        first = 1'b0;
        last  = 1'b0;
        for (int i = 0; i < PAT_CAP; i++)
            pat_bytes[i] = 8'h00;
        pat_len    = 0;
        ovf_sticky = 1'b0;
        clear_row();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_pattern();
        test_byte_extremes();
        test_abandon_and_ignore();
        test_pattern_full();
        test_long_string();
        drain_results();
        test_random_traffic();

        // let the last results out, then allow for stray strobes
        drain_results();
        repeat (PIPE_LAT + 16) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
